/* design/assert_macros.svh */
// Assertion macros shared by the CTC greedy decoder RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/cgd_pkg.sv */
// Shared widths, limits and types for the CTC greedy decoder.
// Depends on nothing; used by every module of the decoder.
package cgd_pkg;

   localparam int unsigned SCORE_BITS = 16;
   localparam int unsigned LABEL_BITS = 13;
   localparam int unsigned SUM_BITS = 24;
   localparam int unsigned COUNT_BITS = 9;
   localparam int unsigned DIV_STEP_BITS = 5;
   localparam int unsigned CGD_QUEUE_DEPTH = 4;

   localparam logic [LABEL_BITS-1:0] CLASS_POS_MAX = '1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // One finished step on its way from the front end to the back end.
   typedef struct packed {
      logic char_valid;
      logic [LABEL_BITS-1:0] label_index;
      logic done_res;
      logic [SUM_BITS-1:0] score_sum;
      logic [COUNT_BITS-1:0] char_count;
   } cgd_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cgd_qstat_type;

endpackage

/* design/cgd_front.sv */
// Front end of the CTC greedy decoder: per-step argmax, repeat and blank
// filtering, running sum and count. Depends on cgd_pkg.
module cgd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [cgd_pkg::SCORE_BITS-1:0] req_class_score,
   input  logic req_step_end,
   input  logic req_sequence_end,
   input  cgd_pkg::cgd_qstat_type q_stat,
   output logic push_valid,
   output cgd_pkg::cgd_entry_type push_entry
);
   import cgd_pkg::*;

   logic [LABEL_BITS-1:0] class_pos_ff, class_pos_in;
   logic [LABEL_BITS-1:0] best_class_ff, best_class_in;
   logic [LABEL_BITS-1:0] prev_winner_ff, prev_winner_in;
   logic [SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic accept;
   logic better;
   logic emit;
   logic [SCORE_BITS-1:0] step_score;
   logic [LABEL_BITS-1:0] winner;
   logic [SUM_BITS:0] sum_wide;
   logic [SUM_BITS-1:0] sum_next;
   logic [COUNT_BITS-1:0] count_next;

   assign req_stall = q_stat.full;

   always_comb begin
      accept = req_valid && !q_stat.full;
      // A later class wins only with a strictly greater score.
      better = req_class_score > best_score_ff;
      step_score = better ? req_class_score : best_score_ff;
      winner = better ? class_pos_ff : best_class_ff;
      emit = (winner != '0) && (winner != prev_winner_ff);
      sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(step_score);
      sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);

      class_pos_in = class_pos_ff;
      best_class_in = best_class_ff;
      best_score_in = best_score_ff;
      prev_winner_in = prev_winner_ff;
      sum_in = sum_ff;
      count_in = count_ff;

      if (accept) begin
         if (!req_step_end) begin
            best_score_in = step_score;
            best_class_in = winner;
            if (class_pos_ff != CLASS_POS_MAX) begin
               class_pos_in = class_pos_ff + LABEL_BITS'(1);
            end
         end else begin
            class_pos_in = '0;
            best_class_in = '0;
            best_score_in = '0;
            if (req_sequence_end) begin
               prev_winner_in = '0;
               sum_in = '0;
               count_in = '0;
            end else begin
               prev_winner_in = winner;
               if (emit) begin
                  sum_in = sum_next;
                  count_in = count_next;
               end
            end
         end
      end

      push_valid = accept && req_step_end && (emit || req_sequence_end);
      push_entry.char_valid = emit;
      push_entry.label_index = emit ? winner - LABEL_BITS'(1) : '0;
      push_entry.done_res = req_sequence_end;
      push_entry.score_sum = emit ? sum_next : sum_ff;
      push_entry.char_count = emit ? count_next : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_pos_ff <= '0;
         best_class_ff <= '0;
         best_score_ff <= '0;
         prev_winner_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
      end else begin
         class_pos_ff <= class_pos_in;
         best_class_ff <= best_class_in;
         best_score_ff <= best_score_in;
         prev_winner_ff <= prev_winner_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

/* design/cgd_queue.sv */
// Short FIFO of finished steps between the decoder front and back ends.
// Depends on cgd_pkg.
module cgd_queue #(
   parameter int unsigned QUEUE_DEPTH = cgd_pkg::CGD_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  cgd_pkg::cgd_entry_type push_entry,
   input  logic pop,
   output cgd_pkg::cgd_entry_type head_entry,
   output cgd_pkg::cgd_qstat_type q_stat
);
   import cgd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   cgd_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      q_stat.empty = (fill_ff == '0);
      q_stat.full = (fill_ff == CNT_W'(QUEUE_DEPTH));
      head_entry = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_valid && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* design/cgd_back.sv */
// Back end of the CTC greedy decoder: mean score by a bit-serial divider
// and the result output register. Depends on cgd_pkg.
module cgd_back (
   input  logic clock,
   input  logic reset,
   input  cgd_pkg::cgd_entry_type head_entry,
   input  cgd_pkg::cgd_qstat_type q_stat,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_char_valid,
   output logic [cgd_pkg::LABEL_BITS-1:0] rsp_label_index,
   output logic rsp_done_res,
   output logic [cgd_pkg::SCORE_BITS-1:0] rsp_mean_score,
   output logic [cgd_pkg::COUNT_BITS-1:0] rsp_char_count
);
   import cgd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   state_type state_ff, state_in;
   cgd_entry_type held_ff, held_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0] quot_ff, quot_in;
   logic [DIV_STEP_BITS-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_char_valid_ff, rsp_char_valid_in;
   logic [LABEL_BITS-1:0] rsp_label_ff, rsp_label_in;
   logic rsp_done_ff, rsp_done_in;
   logic [SCORE_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic out_free;
   logic needs_div;
   logic take;
   logic [COUNT_BITS:0] shifted;
   logic [COUNT_BITS:0] diff;
   logic [SCORE_BITS-1:0] mean_capped;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      needs_div = head_entry.done_res && (head_entry.char_count != '0);
      // Restoring division, one quotient bit per cycle, dividend MSB first.
      shifted = {rem_ff, quot_ff[SUM_BITS-1]};
      take = shifted >= {1'b0, held_ff.char_count};
      diff = shifted - {1'b0, held_ff.char_count};
      mean_capped = (quot_ff[SUM_BITS-1:SCORE_BITS] != '0) ? '1
                                                           : quot_ff[SCORE_BITS-1:0];

      pop = 1'b0;
      state_in = state_ff;
      held_in = held_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_valid_in = rsp_char_valid_ff;
      rsp_label_in = rsp_label_ff;
      rsp_done_in = rsp_done_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty && out_free) begin
               pop = 1'b1;
               held_in = head_entry;
               if (needs_div) begin
                  quot_in = head_entry.score_sum;
                  rem_in = '0;
                  step_in = '0;
                  state_in = ST_DIVIDE;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_char_valid_in = head_entry.char_valid;
                  rsp_label_in = head_entry.label_index;
                  rsp_done_in = head_entry.done_res;
                  rsp_mean_in = '0;
                  rsp_count_in = head_entry.char_count;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = take ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quot_in = {quot_ff[SUM_BITS-2:0], take};
            step_in = step_ff + DIV_STEP_BITS'(1);
            if (step_ff == DIV_STEP_BITS'(SUM_BITS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_valid_in = held_ff.char_valid;
               rsp_label_in = held_ff.label_index;
               rsp_done_in = held_ff.done_res;
               rsp_mean_in = mean_capped;
               rsp_count_in = held_ff.char_count;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff <= held_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      rsp_char_valid_ff <= rsp_char_valid_in;
      rsp_label_ff <= rsp_label_in;
      rsp_done_ff <= rsp_done_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char_valid = rsp_char_valid_ff;
   assign rsp_label_index = rsp_label_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_mean_score = rsp_mean_ff;
   assign rsp_char_count = rsp_count_ff;

endmodule

/* design/ctc_greedy_decoder.sv */
// CTC greedy decoder, top level. Takes one class score request per cycle while
// req_stall is low. A result with no division passes through the queue and then the
// result output register after its step-end request is taken; a sequence end with
// characters also runs the 24-step bit-serial mean divider, holding the back end.
// A queue of QUEUE_DEPTH finished steps lets the front keep taking requests meanwhile.
// Reset is synchronous and active high; it clears all sequence and control state.
`include "assert_macros.svh"

module ctc_greedy_decoder #(
   parameter int unsigned QUEUE_DEPTH = cgd_pkg::CGD_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [cgd_pkg::SCORE_BITS-1:0] req_class_score,
   input  logic req_step_end,
   input  logic req_sequence_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_char_valid,
   output logic [cgd_pkg::LABEL_BITS-1:0] rsp_label_index,
   output logic rsp_done_res,
   output logic [cgd_pkg::SCORE_BITS-1:0] rsp_mean_score,
   output logic [cgd_pkg::COUNT_BITS-1:0] rsp_char_count
);
   import cgd_pkg::*;

   // The front end tracks the best class of the current time step, decides
   // at each step end whether a character is emitted, and keeps the running
   // score sum and character count. Every step end that emits a character
   // or closes the sequence becomes one queue entry.
   logic push_valid;
   logic pop;
   cgd_entry_type push_entry;
   cgd_entry_type head_entry;
   cgd_qstat_type q_stat;

   cgd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_class_score  (req_class_score),
      .req_step_end     (req_step_end),
      .req_sequence_end (req_sequence_end),
      .q_stat           (q_stat),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   // The queue decouples the two halves, so a long division at sequence end
   // does not hold up the score stream until the queue fills.
   cgd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   // The back end turns each entry into one result. Sequence-end entries
   // with at least one character go through the serial divider first.
   cgd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_label_index (rsp_label_index),
      .rsp_done_res    (rsp_done_res),
      .rsp_mean_score  (rsp_mean_score),
      .rsp_char_count  (rsp_char_count)
   );

   // A push into a full queue would drop a result.
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push_valid, !q_stat.full)
   // The back end never pops an empty queue.
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !q_stat.empty)
   // A push without a pop leaves something in the queue.
   `ASSERT_NEXT(a_push_fills, clock, reset, push_valid && !pop, !q_stat.empty)
   // Every result carries a character, a sequence end, or both.
   `ASSERT_IMPLIES(a_result_has_content, clock, reset,
                   rsp_valid && !rsp_char_valid, rsp_done_res)

endmodule
